@@ hdl/cabd_pkg.sv @@
// Shared types, constants and the division step of the contact avoidance bound
package cabd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QSH       = FRAC_BITS + 1;
    localparam int DIV_W     = 63;
    localparam int DIV_STEPS = 63;

    localparam logic [0:0] REG_HORIZON = 1'd0;
    localparam logic [0:0] REG_MARGIN  = 1'd1;

    localparam logic [30:0] HORIZON_RST = 31'd32768;
    localparam logic [30:0] MARGIN_RST  = 31'd3277;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [31:0] velocity;
        logic signed [31:0] jacobian_drift;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] accel_bound;
        logic               clamped;
        logic               saturated;
    } res_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] word;
        logic [DIV_W-1:0] div;
    } lane_t;

    typedef struct packed {
        logic [31:0] drift;
        logic        nneg;
        logic        ovf;
        logic        cond;
        logic        d_zero;
        logic        d_pos;
    } side_t;

    // One restoring step: quotient bits shift in where dividend bits leave
    function automatic lane_t div_step(lane_t l);
        logic [DIV_W-1:0] t;
        lane_t            r;
        t     = {l.rem[DIV_W-2:0], l.word[DIV_W-1]};
        r.div = l.div;
        if (t >= l.div)
        begin
            r.rem  = t - l.div;
            r.word = {l.word[DIV_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t;
            r.word = {l.word[DIV_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ hdl/cabd_cfg.sv @@
// APB register block: horizon and safety margin
module cabd_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [30:0] horizon,
    output logic [30:0] margin
);

    logic [30:0] horizon_reg;
    logic [30:0] margin_reg;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= cabd_pkg::HORIZON_RST;
            margin_reg  <= cabd_pkg::MARGIN_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                cabd_pkg::REG_HORIZON: horizon_reg <= pwdata[30:0];
                cabd_pkg::REG_MARGIN:  margin_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            cabd_pkg::REG_HORIZON: prdata = {1'b0, horizon_reg};
            cabd_pkg::REG_MARGIN:  prdata = {1'b0, margin_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign horizon = horizon_reg;
    assign margin  = margin_reg;

endmodule

@@ hdl/cabd_front.sv @@
// Front stages: capture, products, numerator and stop test, divider set-up
module cabd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cabd_pkg::cmd_t      cmd,
    input  logic [30:0]         horizon,
    input  logic [30:0]         margin,
    output logic                vld,
    output cabd_pkg::lane_t     q_lane,
    output cabd_pkg::lane_t     m_lane,
    output cabd_pkg::side_t     side
);

    // stage A
    cabd_pkg::cmd_t  cmd_a_reg;
    logic            vld_a_reg;
    // stage B
    logic [32:0]     d_b_reg, d_b_next;
    logic [63:0]     vh_b_reg, vh_b_next;
    logic [61:0]     h2_b_reg, h2_b_next;
    logic [62:0]     vv_b_reg, vv_b_next;
    logic [62:0]     hv_b_reg, hv_b_next;
    logic            vnz_b_reg, vneg_b_reg;
    logic [31:0]     drift_b_reg;
    logic            vld_b_reg;
    // stage C
    logic [63:0]     nabs_c_reg, nabs_c_next;
    logic [61:0]     h2_c_reg;
    logic [62:0]     vv_c_reg;
    logic [33:0]     dden_c_reg, dden_c_next;
    cabd_pkg::side_t side_c_reg, side_c_next;
    logic            vld_c_reg;
    // stage D
    cabd_pkg::lane_t q_d_reg, q_d_next;
    cabd_pkg::lane_t m_d_reg, m_d_next;
    cabd_pkg::side_t side_d_reg, side_d_next;
    logic            vld_d_reg;

    logic [30:0]     hz;
    logic [31:0]     vabs;
    logic [63:0]     num;
    logic [32:0]     dabs;
    logic            dz;

    assign hz = (horizon == 31'd0) ? 31'd1 : horizon;

    always_comb
    begin
        vabs      = cmd_a_reg.velocity[31] ? (32'd0 - cmd_a_reg.velocity) : cmd_a_reg.velocity;
        d_b_next  = {cmd_a_reg.distance[31], cmd_a_reg.distance} - {2'b00, margin};
        vh_b_next = {{32{cmd_a_reg.velocity[31]}}, cmd_a_reg.velocity} * {33'd0, hz};
        h2_b_next = {31'd0, hz} * {31'd0, hz};
        vv_b_next = 63'({32'd0, vabs} * {32'd0, vabs});
        hv_b_next = {32'd0, hz} * {31'd0, vabs};
    end

    always_comb
    begin
        num         = ({{31{d_b_reg[32]}}, d_b_reg} << cabd_pkg::FRAC_BITS) - vh_b_reg;
        nabs_c_next = num[63] ? (64'd0 - num) : num;
        dabs        = d_b_reg[32] ? (33'd0 - d_b_reg) : d_b_reg;
        dz          = (d_b_reg == 33'd0);
        dden_c_next = {dabs, 1'b0};
        side_c_next.drift  = drift_b_reg;
        side_c_next.nneg   = num[63];
        side_c_next.ovf    = 1'b0;
        side_c_next.d_zero = dz;
        side_c_next.d_pos  = !d_b_reg[32] && !dz;
        side_c_next.cond   = vnz_b_reg && (dz || (d_b_reg[32] == vneg_b_reg))
                             && ((64'(dabs) << cabd_pkg::QSH) <= {1'b0, hv_b_reg});
    end

    always_comb
    begin
        side_d_next     = side_c_reg;
        // the capped quotient: anything at or above 2^62 saturates the sum anyway
        side_d_next.ovf = (nabs_c_reg >> (62 - cabd_pkg::QSH)) >= {2'b00, h2_c_reg};
        q_d_next.rem    = 63'(nabs_c_reg >> (cabd_pkg::DIV_W - cabd_pkg::QSH));
        q_d_next.word   = 63'(nabs_c_reg << cabd_pkg::QSH);
        q_d_next.div    = {1'b0, h2_c_reg};
        m_d_next.rem    = 63'd0;
        m_d_next.word   = vv_c_reg;
        m_d_next.div    = {29'd0, dden_c_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= start;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_a_reg   <= cmd;
        d_b_reg     <= d_b_next;
        vh_b_reg    <= vh_b_next;
        h2_b_reg    <= h2_b_next;
        vv_b_reg    <= vv_b_next;
        hv_b_reg    <= hv_b_next;
        vnz_b_reg   <= (cmd_a_reg.velocity != 32'sd0);
        vneg_b_reg  <= cmd_a_reg.velocity[31];
        drift_b_reg <= cmd_a_reg.jacobian_drift;
        nabs_c_reg  <= nabs_c_next;
        h2_c_reg    <= h2_b_reg;
        vv_c_reg    <= vv_b_reg;
        dden_c_reg  <= dden_c_next;
        side_c_reg  <= side_c_next;
        q_d_reg     <= q_d_next;
        m_d_reg     <= m_d_next;
        side_d_reg  <= side_d_next;
    end

    assign vld    = vld_d_reg;
    assign q_lane = q_d_reg;
    assign m_lane = m_d_reg;
    assign side   = side_d_reg;

endmodule

@@ hdl/cabd_div.sv @@
// Two pipelined restoring dividers, one quotient bit per stage, with sideband
module cabd_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  cabd_pkg::lane_t  q_in,
    input  cabd_pkg::lane_t  m_in,
    input  cabd_pkg::side_t  side_in,
    output logic             out_vld,
    output logic [62:0]      q,
    output logic [62:0]      m,
    output cabd_pkg::side_t  side_out
);

    localparam int N = cabd_pkg::DIV_STEPS;

    cabd_pkg::lane_t q_reg    [N];
    cabd_pkg::lane_t q_next   [N];
    cabd_pkg::lane_t m_reg    [N];
    cabd_pkg::lane_t m_next   [N];
    cabd_pkg::side_t side_reg [N];
    logic [N-1:0]    vld_reg;

    always_comb
    begin
        q_next[0] = cabd_pkg::div_step(q_in);
        m_next[0] = cabd_pkg::div_step(m_in);
        for (int k = 1; k < N; k++)
        begin
            q_next[k] = cabd_pkg::div_step(q_reg[k-1]);
            m_next[k] = cabd_pkg::div_step(m_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[N-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int k = 0; k < N; k++)
        begin
            q_reg[k] <= q_next[k];
            m_reg[k] <= m_next[k];
        end
        for (int k = 1; k < N; k++)
            side_reg[k] <= side_reg[k-1];
    end

    assign out_vld  = vld_reg[N-1];
    assign q        = q_reg[N-1].word;
    assign m        = m_reg[N-1].word;
    assign side_out = side_reg[N-1];

endmodule

@@ hdl/cabd_back.sv @@
// Back stages: horizon bound sum, stopping limit, clamp and saturation
module cabd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [62:0]      q,
    input  logic [62:0]      m,
    input  cabd_pkg::side_t  side,
    output logic             done,
    output cabd_pkg::res_t   result
);

    logic signed [64:0] b_reg, b_next;
    logic signed [64:0] lim_reg, lim_next;
    logic               cond_reg, dz_reg, vld_reg;
    cabd_pkg::res_t     res_reg, res_next;
    logic               done_reg;

    logic [62:0]        qv;
    logic signed [64:0] qs;
    logic               take;
    logic               neg_inf;
    logic signed [64:0] bf;

    always_comb
    begin
        qv       = side.ovf ? (63'd1 << 62) : q;
        qs       = side.nneg ? (65'sd0 - $signed({2'b00, qv})) : $signed({2'b00, qv});
        b_next   = qs - $signed({{33{side.drift[31]}}, side.drift});
        lim_next = side.d_pos ? (65'sd0 - $signed({2'b00, m})) : $signed({2'b00, m});
    end

    always_comb
    begin
        neg_inf  = cond_reg && dz_reg;
        take     = cond_reg && !dz_reg && (b_reg >= lim_reg);
        bf       = take ? lim_reg : b_reg;
        res_next.clamped = take || neg_inf;
        if (neg_inf)
        begin
            res_next.accel_bound = 32'sh8000_0000;
            res_next.saturated   = 1'b1;
        end
        else if (bf > 65'sd2147483647)
        begin
            res_next.accel_bound = 32'sh7FFF_FFFF;
            res_next.saturated   = 1'b1;
        end
        else if (bf < -65'sd2147483648)
        begin
            res_next.accel_bound = 32'sh8000_0000;
            res_next.saturated   = 1'b1;
        end
        else
        begin
            res_next.accel_bound = bf[31:0];
            res_next.saturated   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= in_vld;
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        lim_reg  <= lim_next;
        cond_reg <= side.cond;
        dz_reg   <= side.d_zero;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ hdl/contact_avoidance_accel_bound.sv @@
// Contact avoidance acceleration bound: top level
// Takes one command per clock (busy never rises) and gives each result on
// result with done high for one cycle. The two 63-step restoring dividers run
// side by side, one quotient bit per pipeline stage, between four front and two
// back stages, the first of which captures the command. Results leave in
// command order and cannot be held off: the receiver must take every beat as
// it comes. Write horizon and safety_margin over APB only while no command is
// in flight.
module contact_avoidance_accel_bound (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cabd_pkg::cmd_t  cmd,
    output logic            done,
    output cabd_pkg::res_t  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [30:0]     horizon;
    logic [30:0]     margin;
    logic            f_vld;
    cabd_pkg::lane_t f_q_lane;
    cabd_pkg::lane_t f_m_lane;
    cabd_pkg::side_t f_side;
    logic            d_vld;
    logic [62:0]     d_q;
    logic [62:0]     d_m;
    cabd_pkg::side_t d_side;

    assign busy = 1'b0;

    cabd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .horizon (horizon),
        .margin  (margin)
    );

    cabd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .horizon (horizon),
        .margin  (margin),
        .vld     (f_vld),
        .q_lane  (f_q_lane),
        .m_lane  (f_m_lane),
        .side    (f_side)
    );

    cabd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (f_vld),
        .q_in     (f_q_lane),
        .m_in     (f_m_lane),
        .side_in  (f_side),
        .out_vld  (d_vld),
        .q        (d_q),
        .m        (d_m),
        .side_out (d_side)
    );

    cabd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (d_vld),
        .q      (d_q),
        .m      (d_m),
        .side   (d_side),
        .done   (done),
        .result (result)
    );

endmodule
